// ===== rtl/assert_macros.svh =====
// Assertion macros shared by the stack machine RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Implication checked on every rising clock edge outside reset.
`define SME_ASSERT_IMPLY(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);
// Next-cycle implication checked outside reset.
`define SME_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);
`endif

// ===== rtl/sme_pkg.sv =====
// Shared types and codes for the stack machine executor.
package sme_pkg;
   typedef enum logic [3:0] {
      OP_PUSH_IMM = 4'd0, OP_PUSH_REG = 4'd1, OP_POP = 4'd2, OP_POP_REG = 4'd3,
      OP_IN = 4'd4, OP_OUT = 4'd5, OP_ADD = 4'd6, OP_SUB = 4'd7, OP_MUL = 4'd8,
      OP_DIV = 4'd9, OP_SQRT = 4'd10, OP_SIN = 4'd11, OP_COS = 4'd12,
      OP_END = 4'd13, OP_ILL14 = 4'd14, OP_ILL15 = 4'd15
   } opcode_type;

   typedef enum logic [2:0] {
      ST_OK = 3'd0, ST_UNDERFLOW = 3'd1, ST_OVERFLOW = 3'd2, ST_DIV_ZERO = 3'd3,
      ST_NEG_ROOT = 3'd4, ST_ILLEGAL = 3'd5, ST_HALTED = 3'd6
   } status_type;

   typedef enum logic [2:0] {
      EX_IDLE, EX_READ, EX_EXEC, EX_DIV, EX_SQRT, EX_DONE
   } exec_state_type;

   // Classified instruction handed from the front end to the back end.
   typedef struct packed {
      opcode_type  opcode;
      logic [1:0]  reg_index;
      logic [31:0] immediate;
      logic [31:0] in_value;
   } instr_type;

   // Control between the back end and its iterative unit.
   typedef struct packed {
      logic start;
      logic is_div;
   } iter_ctrl_type;
endpackage

// ===== rtl/stack_machine_executor.sv =====
// Stack machine executor: a front-end queue and an executing back end.
// Each instruction transfer is queued by the front end; the back end pops it, reads the top
// two stack entries from the stack memory, executes, and registers one response. The back
// end pops the next instruction the cycle after the response transfer, so it works on one
// instruction at a time; a div or sqrt without a fault runs in the bit-serial divide/root
// unit before its response is registered. The two-entry queue keeps taking requests while
// the back end works or a response waits, and stalls the requester once it is full. Fault
// codes leave all state untouched; after end every instruction reports halted.
module stack_machine_executor #(
   parameter int STACK_DEPTH = 64,
   parameter int DATA_WIDTH  = 32
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [3:0]  req_opcode,
   input  logic [1:0]  req_reg_index,
   input  logic signed [31:0] req_immediate,
   input  logic signed [31:0] req_in_value,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic        rsp_out_valid,
   output logic signed [31:0] rsp_out_value,
   output logic [2:0]  rsp_status,
   output logic        rsp_halted
);
   import sme_pkg::*;

   logic      q_valid, q_pop;
   instr_type q_instr;

   sme_front u_front (
      .clock, .reset, .req_valid, .req_stall, .req_opcode, .req_reg_index,
      .req_immediate, .req_in_value, .q_valid, .q_instr, .q_pop
   );

   sme_back #(.STACK_DEPTH(STACK_DEPTH), .DATA_WIDTH(DATA_WIDTH)) u_back (
      .clock, .reset, .q_valid, .q_instr, .q_pop, .rsp_valid, .rsp_stall,
      .rsp_out_valid, .rsp_out_value, .rsp_status, .rsp_halted
   );
endmodule

// ===== rtl/sme_front.sv =====
// Front end: takes instruction transfers into a two-entry queue.
module sme_front (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic [3:0]         req_opcode,
   input  logic [1:0]         req_reg_index,
   input  logic [31:0]        req_immediate,
   input  logic [31:0]        req_in_value,
   output logic               q_valid,
   output sme_pkg::instr_type q_instr,
   input  logic               q_pop
);
   import sme_pkg::*;

   instr_type  slot_ff [2];
   logic [1:0] count_ff, count_in;
   logic       rd_ff, rd_in, wr_ff, wr_in;
   logic       push;
   instr_type  item;

   assign req_stall = count_ff[1];
   assign push      = req_valid && !req_stall;
   assign q_valid   = count_ff != 2'd0;
   assign q_instr   = slot_ff[rd_ff];
   assign item      = '{opcode: opcode_type'(req_opcode), reg_index: req_reg_index,
                        immediate: req_immediate, in_value: req_in_value};

   always_comb begin
      count_in = count_ff + {1'b0, push} - {1'b0, q_pop && q_valid};
      rd_in    = rd_ff ^ (q_pop && q_valid);
      wr_in    = wr_ff ^ push;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= 2'd0;
         rd_ff    <= 1'b0;
         wr_ff    <= 1'b0;
      end else begin
         count_ff <= count_in;
         rd_ff    <= rd_in;
         wr_ff    <= wr_in;
      end
      if (push) slot_ff[wr_ff] <= item;
   end

`include "assert_macros.svh"
   `SME_ASSERT_IMPLY(a_no_overfill, clock, reset, count_ff == 2'd2, !push, "queue overfilled")
   `SME_ASSERT_NEXT(a_count_step, clock, reset, push && !(q_pop && q_valid),
      count_ff == $past(count_ff) + 2'd1, "queue count did not advance")
   `SME_ASSERT_IMPLY(a_count_range, clock, reset, 1'b1, count_ff <= 2'd2, "queue count out of range")
endmodule

// ===== rtl/sme_iter.sv =====
// Iterative unit: unsigned restoring divide and integer square root, one bit a cycle.
module sme_iter #(
   parameter int DATA_WIDTH = 32
) (
   input  logic                    clock,
   input  logic                    reset,
   input  sme_pkg::iter_ctrl_type  ctrl,
   input  logic [DATA_WIDTH-1:0]   op_a,
   input  logic [DATA_WIDTH-1:0]   op_b,
   output logic                    busy,
   output logic [DATA_WIDTH-1:0]   result
);
   import sme_pkg::*;

   localparam int CW = $clog2(DATA_WIDTH + 1);
   localparam int HW = DATA_WIDTH / 2;

   logic [DATA_WIDTH-1:0] quo_ff, quo_in, num_ff, num_in, den_ff;
   logic [DATA_WIDTH+1:0] rem_ff, rem_in, trial;
   logic [CW-1:0]         cnt_ff, cnt_in;
   logic                  div_ff, busy_ff, busy_in;

   assign busy   = busy_ff;
   assign result = quo_ff;

   always_comb begin
      quo_in  = quo_ff;
      num_in  = num_ff;
      rem_in  = rem_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      trial   = '0;
      if (ctrl.start) begin
         quo_in  = '0;
         // Odd width root: drop the clear sign bit so bit pairs line up.
         num_in  = (ctrl.is_div || DATA_WIDTH % 2 == 0) ? op_a : op_a << 1;
         rem_in  = '0;
         cnt_in  = ctrl.is_div ? CW'(DATA_WIDTH) : CW'(HW);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (div_ff) begin
            trial  = {rem_ff[DATA_WIDTH:0], num_ff[DATA_WIDTH-1]};
            num_in = num_ff << 1;
            if (trial >= {2'b00, den_ff}) begin
               rem_in = trial - {2'b00, den_ff};
               quo_in = {quo_ff[DATA_WIDTH-2:0], 1'b1};
            end else begin
               rem_in = trial;
               quo_in = {quo_ff[DATA_WIDTH-2:0], 1'b0};
            end
         end else begin
            // Bring down two bits, try root*4+1.
            trial  = {rem_ff[DATA_WIDTH-1:0], num_ff[DATA_WIDTH-1:DATA_WIDTH-2]};
            num_in = num_ff << 2;
            if (trial >= {quo_ff, 2'b01}) begin
               rem_in = trial - {quo_ff, 2'b01};
               quo_in = {quo_ff[DATA_WIDTH-2:0], 1'b1};
            end else begin
               rem_in = trial;
               quo_in = {quo_ff[DATA_WIDTH-2:0], 1'b0};
            end
         end
         cnt_in = cnt_ff - CW'(1);
         if (cnt_ff == CW'(1)) busy_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         cnt_ff  <= cnt_in;
      end
      quo_ff <= quo_in;
      num_ff <= num_in;
      rem_ff <= rem_in;
      if (ctrl.start) begin
         den_ff <= op_b;
         div_ff <= ctrl.is_div;
      end
   end

`include "assert_macros.svh"
   `SME_ASSERT_NEXT(a_start_busy, clock, reset, ctrl.start, busy, "unit did not go busy")
   `SME_ASSERT_IMPLY(a_cnt_live, clock, reset, busy, cnt_ff != '0, "busy with zero count")
   `SME_ASSERT_IMPLY(a_no_restart, clock, reset, busy, !ctrl.start, "start while busy")
endmodule

// ===== rtl/sme_back.sv =====
// Back end: stack memory, registers and instruction execution.
module sme_back #(
   parameter int STACK_DEPTH = 64,
   parameter int DATA_WIDTH  = 32
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               q_valid,
   input  sme_pkg::instr_type q_instr,
   output logic               q_pop,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic               rsp_out_valid,
   output logic [31:0]        rsp_out_value,
   output logic [2:0]         rsp_status,
   output logic               rsp_halted
);
   import sme_pkg::*;

   localparam int AW = $clog2(STACK_DEPTH);
   localparam int CW = $clog2(STACK_DEPTH + 1);
   localparam int DW = DATA_WIDTH;

   logic [DW-1:0] mem [STACK_DEPTH];
   logic [DW-1:0] top_ff, nxt_ff;      // registered reads of top and below-top
   logic [DW-1:0] regs_ff [4];
   logic [CW-1:0] cnt_ff, cnt_in;
   logic          halt_ff, halt_in;
   exec_state_type st_ff, st_in;
   instr_type     ins_ff;

   logic          ov_ff, ov_in;
   logic [31:0]   oval_ff, oval_in;
   status_type    ostat_ff, ostat_in;
   logic          vld_ff, vld_in;

   logic          wr_en;
   logic [AW-1:0] wr_addr;
   logic [DW-1:0] wr_data;
   logic [1:0]    rg_sel;
   logic          rg_wr;
   logic [DW-1:0] rg_data;

   iter_ctrl_type ictl;
   logic          ibusy;
   logic [DW-1:0] ires, mag_a, mag_b, quot;
   logic [DW-1:0] sext_imm, sext_in, prod;
   logic          neg_q;
   logic [AW-1:0] top_addr, nxt_addr;

   assign sext_imm = DW'({{(DW > 32 ? DW - 32 : 1){ins_ff.immediate[31]}},
                         ins_ff.immediate});
   assign sext_in  = DW'({{(DW > 32 ? DW - 32 : 1){ins_ff.in_value[31]}}, ins_ff.in_value});
   assign top_addr = AW'(cnt_ff - CW'(1));
   assign nxt_addr = AW'(cnt_ff - CW'(2));
   assign mag_a    = nxt_ff[DW-1] ? -nxt_ff : nxt_ff;
   assign mag_b    = top_ff[DW-1] ? -top_ff : top_ff;
   assign neg_q    = nxt_ff[DW-1] ^ top_ff[DW-1];
   assign quot     = neg_q ? -ires : ires;
   assign prod     = DW'(nxt_ff * top_ff);

   assign rsp_valid     = vld_ff;
   assign rsp_out_valid = ov_ff;
   assign rsp_out_value = oval_ff;
   assign rsp_status    = ostat_ff;
   assign rsp_halted    = halt_ff;

   // Next state.
   always_comb begin
      st_in = st_ff;
      case (st_ff)
         EX_IDLE: if (q_valid && !vld_ff) st_in = EX_READ;
         EX_READ: st_in = EX_EXEC;
         EX_EXEC: begin
            if (ins_ff.opcode == OP_DIV && cnt_ff >= CW'(2) && top_ff != '0 && !halt_ff)
               st_in = EX_DIV;
            else if (ins_ff.opcode == OP_SQRT && cnt_ff != '0 && !top_ff[DW-1] && !halt_ff)
               st_in = EX_SQRT;
            else
               st_in = EX_IDLE;
         end
         EX_DIV:  if (!ibusy) st_in = EX_IDLE;
         EX_SQRT: if (!ibusy) st_in = EX_IDLE;
         default: st_in = EX_IDLE;
      endcase
   end

   // Outputs and datapath.
   always_comb begin
      q_pop    = 1'b0;
      cnt_in   = cnt_ff;
      halt_in  = halt_ff;
      vld_in   = vld_ff && rsp_stall;
      ov_in    = ov_ff;
      oval_in  = oval_ff;
      ostat_in = ostat_ff;
      wr_en    = 1'b0;
      wr_addr  = top_addr;
      wr_data  = '0;
      rg_wr    = 1'b0;
      rg_sel   = ins_ff.reg_index;
      rg_data  = top_ff;
      ictl     = '{start: 1'b0, is_div: 1'b0};
      case (st_ff)
         EX_IDLE: if (q_valid && !vld_ff) q_pop = 1'b1;
         EX_EXEC: begin
            ov_in    = 1'b0;
            oval_in  = '0;
            ostat_in = ST_OK;
            vld_in   = 1'b1;
            if (halt_ff) begin
               ostat_in = ST_HALTED;
            end else begin
               case (ins_ff.opcode)
                  OP_PUSH_IMM, OP_PUSH_REG, OP_IN: begin
                     if (cnt_ff == CW'(STACK_DEPTH)) ostat_in = ST_OVERFLOW;
                     else begin
                        wr_en   = 1'b1;
                        wr_addr = AW'(cnt_ff);
                        wr_data = (ins_ff.opcode == OP_PUSH_IMM) ? sext_imm :
                                  (ins_ff.opcode == OP_PUSH_REG) ? regs_ff[ins_ff.reg_index]
                                                                 : sext_in;
                        cnt_in  = cnt_ff + CW'(1);
                     end
                  end
                  OP_POP, OP_POP_REG, OP_OUT: begin
                     if (cnt_ff == '0) ostat_in = ST_UNDERFLOW;
                     else begin
                        cnt_in = cnt_ff - CW'(1);
                        rg_wr  = ins_ff.opcode == OP_POP_REG;
                        if (ins_ff.opcode == OP_OUT) begin
                           ov_in   = 1'b1;
                           oval_in = 32'({{(DW < 32 ? 32 - DW : 1){top_ff[DW-1]}}, top_ff});
                        end
                     end
                  end
                  OP_ADD, OP_SUB, OP_MUL, OP_DIV: begin
                     if (cnt_ff < CW'(2)) ostat_in = ST_UNDERFLOW;
                     else if (ins_ff.opcode == OP_DIV) begin
                        if (top_ff == '0) ostat_in = ST_DIV_ZERO;
                        else begin
                           vld_in = 1'b0;
                           ictl   = '{start: 1'b1, is_div: 1'b1};
                        end
                     end else begin
                        wr_en   = 1'b1;
                        wr_addr = nxt_addr;
                        wr_data = (ins_ff.opcode == OP_ADD) ? nxt_ff + top_ff :
                                  (ins_ff.opcode == OP_SUB) ? nxt_ff - top_ff : prod;
                        cnt_in  = cnt_ff - CW'(1);
                     end
                  end
                  OP_SQRT, OP_SIN, OP_COS: begin
                     if (cnt_ff == '0) ostat_in = ST_UNDERFLOW;
                     else if (ins_ff.opcode == OP_SQRT) begin
                        if (top_ff[DW-1]) ostat_in = ST_NEG_ROOT;
                        else begin
                           vld_in = 1'b0;
                           ictl   = '{start: 1'b1, is_div: 1'b0};
                        end
                     end else begin
                        wr_en   = 1'b1;
                        wr_data = (ins_ff.opcode == OP_COS && top_ff == '0) ? DW'(1) : '0;
                     end
                  end
                  OP_END: halt_in = 1'b1;
                  default: ostat_in = ST_ILLEGAL;
               endcase
            end
         end
         EX_DIV: if (!ibusy) begin
            wr_en   = 1'b1;
            wr_addr = nxt_addr;
            wr_data = quot;
            cnt_in  = cnt_ff - CW'(1);
            vld_in  = 1'b1;
         end
         EX_SQRT: if (!ibusy) begin
            wr_en   = 1'b1;
            wr_data = ires;
            vld_in  = 1'b1;
         end
         default: ;
      endcase
   end

   sme_iter #(.DATA_WIDTH(DW)) u_iter (
      .clock(clock), .reset(reset), .ctrl(ictl),
      .op_a(ictl.is_div ? mag_a : top_ff), .op_b(mag_b),
      .busy(ibusy), .result(ires)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff   <= EX_IDLE;
         cnt_ff  <= '0;
         halt_ff <= 1'b0;
         vld_ff  <= 1'b0;
         for (int i = 0; i < 4; i++) regs_ff[i] <= '0;
      end else begin
         st_ff   <= st_in;
         cnt_ff  <= cnt_in;
         halt_ff <= halt_in;
         vld_ff  <= vld_in;
         if (rg_wr) regs_ff[rg_sel] <= rg_data;
      end
      ov_ff    <= ov_in;
      oval_ff  <= oval_in;
      ostat_ff <= ostat_in;
      if (q_pop) ins_ff <= q_instr;
   end

   // Stack memory: one write port, two registered read ports.
   always_ff @(posedge clock) begin
      if (wr_en) mem[wr_addr] <= wr_data;
      top_ff <= mem[top_addr];
      nxt_ff <= mem[nxt_addr];
   end

`include "assert_macros.svh"
   `SME_ASSERT_IMPLY(a_depth, clock, reset, 1'b1, cnt_ff <= CW'(STACK_DEPTH), "stack overrun")
   `SME_ASSERT_IMPLY(a_pop_idle, clock, reset, q_pop, st_ff == EX_IDLE && !vld_ff, "pop while busy")
   `SME_ASSERT_NEXT(a_halt_sticky, clock, reset, halt_ff, halt_ff, "halt flag cleared")
endmodule

// ===== bench/tb.sv =====
// Self-checking bench for the stack machine executor: directed and random programs checked against a predictor.
module tb;
   import sme_pkg::*;

   localparam int DEPTH = 64;
   localparam int WATCH_LIMIT = 20000;

   typedef struct {
      opcode_type  op;
      logic [1:0]  ri;
      logic [31:0] imm;
      logic [31:0] inv;
   } instr_t;

   typedef struct {
      logic        ov;
      logic [31:0] oval;
      status_type  st;
      logic        hlt;
   } outcome_t;

   logic clock = 0;
   logic reset = 1;
   logic req_valid = 0;
   logic req_stall;
   logic [3:0] req_opcode = 0;
   logic [1:0] req_reg_index = 0;
   logic signed [31:0] req_immediate = 0;
   logic signed [31:0] req_in_value = 0;
   logic rsp_valid;
   logic rsp_stall = 0;
   logic rsp_out_valid;
   logic signed [31:0] rsp_out_value;
   logic [2:0] rsp_status;
   logic rsp_halted;

   stack_machine_executor dut (.*);

   initial forever #1 clock = ~clock;

   instr_t   program_q[$];
   outcome_t expected_q[$];
   int       errors = 0;
   int       watch = 0;
   bit       hold_sender = 0;
   int       gap = 0;
   int       burst = 0;

   // predictor state
   logic [31:0] stk[DEPTH];
   int          depth_now;
   logic [31:0] gpr[4] = '{default: 32'd0};
   bit          halt_now;
   int          model_depth; // stack depth tracked while generating

   function automatic logic [31:0] floor_root(logic [31:0] v);
      logic [31:0] r;
      logic [31:0] b;
      r = 0;
      b = 32'h4000_0000;
      while (b > v) b = b >> 2;
      while (b != 0) begin
         if (v >= r + b) begin
            v = v - (r + b);
            r = (r >> 1) + b;
         end else begin
            r = r >> 1;
         end
         b = b >> 2;
      end
      return r;
   endfunction

   function automatic outcome_t execute_instr(instr_t it);
      outcome_t o;
      logic [31:0] a, b, r, ma, mb;
      o.ov = 0; o.oval = 0; o.st = ST_OK;
      if (halt_now) o.st = ST_HALTED;
      else case (it.op)
         OP_PUSH_IMM, OP_PUSH_REG, OP_IN: begin
            if (depth_now >= DEPTH) o.st = ST_OVERFLOW;
            else begin
               stk[depth_now] = (it.op == OP_PUSH_IMM) ? it.imm :
                                (it.op == OP_PUSH_REG) ? gpr[it.ri] : it.inv;
               depth_now++;
            end
         end
         OP_POP, OP_POP_REG, OP_OUT: begin
            if (depth_now == 0) o.st = ST_UNDERFLOW;
            else begin
               depth_now--;
               r = stk[depth_now];
               if (it.op == OP_POP_REG) gpr[it.ri] = r;
               if (it.op == OP_OUT) begin
                  o.ov = 1;
                  o.oval = r;
               end
            end
         end
         OP_ADD, OP_SUB, OP_MUL, OP_DIV: begin
            if (depth_now < 2) o.st = ST_UNDERFLOW;
            else begin
               a = stk[depth_now-2];
               b = stk[depth_now-1];
               r = 0;
               case (it.op)
                  OP_ADD: r = a + b;
                  OP_SUB: r = a - b;
                  OP_MUL: r = a * b;
                  default: begin
                     if (b == 0) o.st = ST_DIV_ZERO;
                     else begin
                        ma = a[31] ? -a : a;
                        mb = b[31] ? -b : b;
                        r = ma / mb;
                        if (a[31] ^ b[31]) r = -r;
                     end
                  end
               endcase
               if (o.st == ST_OK) begin
                  depth_now--;
                  stk[depth_now-1] = r;
               end
            end
         end
         OP_SQRT, OP_SIN, OP_COS: begin
            if (depth_now == 0) o.st = ST_UNDERFLOW;
            else begin
               a = stk[depth_now-1];
               if (it.op == OP_SQRT) begin
                  if (a[31]) o.st = ST_NEG_ROOT;
                  else stk[depth_now-1] = floor_root(a);
               end else if (it.op == OP_SIN) stk[depth_now-1] = 0;
               else stk[depth_now-1] = (a == 0) ? 32'd1 : 32'd0;
            end
         end
         OP_END: halt_now = 1;
         default: o.st = ST_ILLEGAL;
      endcase
      o.hlt = halt_now;
      return o;
   endfunction

   function automatic logic [31:0] rand_word();
      case ($urandom_range(0, 5))
         0: return 32'h8000_0000;
         1: return 32'h7fff_ffff;
         2: return 32'hffff_ffff;
         3: return 32'd0;
         4: return $urandom_range(0, 40) - 20;
         default: return $urandom;
      endcase
   endfunction

   task automatic add_instr(opcode_type op, logic [31:0] imm = 0);
      instr_t it;
      it.op = op;
      it.ri = $urandom_range(0, 3);
      it.imm = imm;
      it.inv = rand_word();
      program_q.push_back(it);
   endtask

   // driver: bursts with random gaps
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 0;
      end else if (!(req_valid && req_stall)) begin
         // drop the item just transferred; the next one is then at the head
         if (req_valid) program_q.pop_front();
         if (gap > 0) begin
            gap <= gap - 1;
            req_valid <= 0;
         end else if (program_q.size() > 0 && !hold_sender) begin
            instr_t it;
            it = program_q[0];
            req_valid <= 1;
            req_opcode <= it.op;
            req_reg_index <= it.ri;
            req_immediate <= it.imm;
            req_in_value <= it.inv;
            if (burst > 0) burst <= burst - 1;
            else begin
               burst <= $urandom_range(0, 12);
               gap <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
            end
         end else begin
            req_valid <= 0;
         end
      end
   end

   // predict on each accepted request
   always @(posedge clock) begin
      if (!reset && req_valid && !req_stall) begin
         instr_t it;
         it.op = opcode_type'(req_opcode);
         it.ri = req_reg_index;
         it.imm = req_immediate;
         it.inv = req_in_value;
         expected_q.push_back(execute_instr(it));
      end
   end

   task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
      $display("mismatch %s: got %0h want %0h", what, got, want);
      errors++;
   endtask

   // monitor and receiver stall pattern
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 0;
      end else begin
         rsp_stall <= ($urandom_range(0, 15) < 5) && ($time % 400 < 300);
         if (rsp_valid && !rsp_stall) begin
            if (expected_q.size() == 0) begin
               $display("mismatch: response with nothing pending");
               errors++;
            end else begin
               outcome_t e;
               e = expected_q.pop_front();
               if (rsp_out_valid !== e.ov) report_mismatch("out_valid", rsp_out_valid, e.ov);
               if (rsp_out_value !== e.oval) report_mismatch("out_value", rsp_out_value, e.oval);
               if (rsp_status !== e.st) report_mismatch("status", rsp_status, e.st);
               if (rsp_halted !== e.hlt) report_mismatch("halted", rsp_halted, e.hlt);
            end
         end
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) watch <= 0;
         else watch <= watch + 1;
         if (watch >= WATCH_LIMIT) begin
            $display("CHECKS FAILED");
            $finish;
         end
      end
   end

   task automatic build_program();
      int n, k;
      opcode_type op;
      // directed: underflows on empty stack, extremes, every op except end
      add_instr(OP_POP); add_instr(OP_OUT); add_instr(OP_ADD); add_instr(OP_SQRT);
      add_instr(OP_ILL14); add_instr(OP_ILL15);
      add_instr(OP_PUSH_IMM, 32'h8000_0000); add_instr(OP_PUSH_IMM, 32'hffff_ffff);
      add_instr(OP_DIV); add_instr(OP_OUT);
      add_instr(OP_PUSH_IMM, 32'h7fff_ffff); add_instr(OP_PUSH_IMM, 32'd0); add_instr(OP_DIV);
      add_instr(OP_SQRT); add_instr(OP_POP_REG); add_instr(OP_PUSH_REG);
      add_instr(OP_PUSH_IMM, 32'hffff_fff0); add_instr(OP_SQRT); add_instr(OP_COS);
      add_instr(OP_COS); add_instr(OP_SIN); add_instr(OP_IN); add_instr(OP_MUL);
      add_instr(OP_SUB); add_instr(OP_OUT);
      // fill to overflow
      for (k = 0; k < DEPTH + 2; k++) add_instr(OP_PUSH_IMM, rand_word());
      for (k = 0; k < DEPTH + 2; k++) add_instr(OP_OUT);
      // random, biased toward keeping the stack shallow but nonempty
      model_depth = 0;
      n = 0;
      while (n < 390) begin
         k = $urandom_range(0, 99);
         if (model_depth < 2 && k < 60) op = (k % 3 == 0) ? OP_IN : OP_PUSH_IMM;
         else if (k < 20) op = OP_PUSH_IMM;
         else if (k < 25) op = OP_PUSH_REG;
         else if (k < 30) op = OP_IN;
         else op = opcode_type'($urandom_range(2, 12));
         if ($urandom_range(0, 199) == 0) op = opcode_type'($urandom_range(14, 15));
         add_instr(op, rand_word());
         if (op == OP_PUSH_IMM || op == OP_PUSH_REG || op == OP_IN) model_depth++;
         else if (op <= OP_OUT && model_depth > 0) model_depth--;
         else if (op >= OP_ADD && op <= OP_DIV && model_depth > 1) model_depth--;
         n++;
      end
      add_instr(OP_END);
      add_instr(OP_PUSH_IMM, 32'd5); add_instr(OP_OUT); add_instr(OP_ILL15);
   endtask

   initial begin
      int wait_n;
      repeat (5) @(posedge clock);
      reset <= 0;
      build_program();
      // pause once until the pipeline drains
      wait (program_q.size() < 400);
      @(posedge clock);
      hold_sender <= 1;
      while (expected_q.size() != 0 || req_valid) @(posedge clock);
      hold_sender <= 0;
      while (program_q.size() != 0) @(posedge clock);
      wait_n = 0;
      while (expected_q.size() != 0 && wait_n < 100000) begin
         @(posedge clock);
         wait_n++;
      end
      repeat (100) @(posedge clock);
      if (errors == 0 && expected_q.size() == 0) $display("ALL CHECKS PASSED");
      else $display("CHECKS FAILED");
      $finish;
   end
endmodule
